FILE: design/hrse_pkg.sv
// ----------------------------------------------------------------------------
// hrse_pkg: shared types and constants of the hex record stream encoder
// Record size, index widths, beat structs, record codes and the hex digit map.
// ----------------------------------------------------------------------------
package hrse_pkg;

	// Data bytes per full record (legal range 1 to 32).
	localparam int RECORD_BYTES = 16;

	// Index into the byte store and width of a byte count (0 to RECORD_BYTES).
	localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int CNT_W  = $clog2(RECORD_BYTES + 1);
	localparam int ADDR_W = 16;

	// Request codes on the input beat.
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_EOF  = 1'b1;

	// Record types (only the low bit of the type byte can be nonzero).
	localparam logic TYPE_DATA = 1'b0;
	localparam logic TYPE_EOF  = 1'b1;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} out_beat_t;

	// Record request from the input side to the record sequencer.
	typedef struct packed {
		logic              start;
		logic              data_rec;
		logic              eof;
		logic [CNT_W-1:0]  count;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

	// Uppercase ASCII hex digit of one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = 8'h30 + {4'h0, nib};
		end else begin
			ch = 8'h37 + {4'h0, nib};
		end
		return ch;
	endfunction

endpackage

FILE: design/hrse_ram.sv
// ----------------------------------------------------------------------------
// hrse_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module hrse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/hrse_seq.sv
// ----------------------------------------------------------------------------
// hrse_seq: record sequencer
// Walks the characters of one or two records, reading each data byte from
// the byte store before its high digit and keeping the checksum as it goes.
// ----------------------------------------------------------------------------
module hrse_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hrse_pkg::cmd_t              cmd,
	output logic                        busy,
	output logic                        rd_en,
	output logic [hrse_pkg::IDX_W-1:0]  rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hrse_pkg::out_beat_t         out_data
);
	import hrse_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_HEAD   = 7'b0000010,
		S_DHI    = 7'b0000100,
		S_DLO    = 7'b0001000,
		S_SUM_HI = 7'b0010000,
		S_SUM_LO = 7'b0100000,
		S_NL     = 7'b1000000
	} seq_state_t;

	localparam logic [3:0] HDR_LAST = 4'd8;

	seq_state_t        state_q, state_d;
	logic              pend_eof_q;
	logic              out_valid_q;
	out_beat_t         out_data_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] addr_q;
	logic              type_q;
	logic [7:0]        sum_q;
	logic [3:0]        hdr_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_next;

	logic              adv;
	logic              load_eof;
	logic              load;
	logic [CNT_W-1:0]  ld_count;
	logic [ADDR_W-1:0] ld_addr;
	logic              ld_type;
	logic [7:0]        ld_sum;
	logic [31:0]       hdr_word;
	logic [3:0]        hdr_nib;
	logic [7:0]        cks;
	logic [7:0]        char_d;
	logic              last_d;

	// A character moves into the output register when it is empty or draining.
	assign adv      = (state_q != S_IDLE) && (!out_valid_q || out_ready);
	assign load_eof = adv && (state_q == S_NL) && pend_eof_q;
	assign load     = cmd.start || load_eof;
	assign idx_next = idx_q + 1'b1;
	assign busy     = (state_q != S_IDLE);

	always_comb begin
		if (cmd.start && cmd.data_rec) begin
			ld_count = cmd.count;
			ld_addr  = cmd.addr;
			ld_type  = TYPE_DATA;
		end else begin
			ld_count = '0;
			ld_addr  = '0;
			ld_type  = TYPE_EOF;
		end
		ld_sum = 8'(ld_count) + ld_addr[15:8] + ld_addr[7:0] + {7'b0, ld_type};
	end

	assign hdr_word = {8'(count_q), addr_q, 7'b0, type_q};
	assign cks      = ~sum_q + 8'd1;

	always_comb begin
		case (hdr_q)
			4'd1:    hdr_nib = hdr_word[31:28];
			4'd2:    hdr_nib = hdr_word[27:24];
			4'd3:    hdr_nib = hdr_word[23:20];
			4'd4:    hdr_nib = hdr_word[19:16];
			4'd5:    hdr_nib = hdr_word[15:12];
			4'd6:    hdr_nib = hdr_word[11:8];
			4'd7:    hdr_nib = hdr_word[7:4];
			4'd8:    hdr_nib = hdr_word[3:0];
			default: hdr_nib = 4'h0;
		endcase
	end

	always_comb begin
		last_d = 1'b0;
		unique case (state_q)
			S_HEAD:   char_d = (hdr_q == 4'd0) ? CH_COLON : hex_char(hdr_nib);
			S_DHI:    char_d = hex_char(rd_data[7:4]);
			S_DLO:    char_d = hex_char(rd_data[3:0]);
			S_SUM_HI: char_d = hex_char(cks[7:4]);
			S_SUM_LO: char_d = hex_char(cks[3:0]);
			S_NL: begin
				char_d = CH_NL;
				last_d = !pend_eof_q;
			end
			default:  char_d = 8'h00;
		endcase
	end

	// Next state; a store read is issued on every step into the high digit.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.start) begin
			state_d = S_HEAD;
		end else if (adv) begin
			unique case (state_q)
				S_HEAD: begin
					if (hdr_q == HDR_LAST) begin
						if (count_q == '0) begin
							state_d = S_SUM_HI;
						end else begin
							state_d = S_DHI;
							rd_en   = 1'b1;
						end
					end
				end
				S_DHI:    state_d = S_DLO;
				S_DLO: begin
					if (idx_next == count_q) begin
						state_d = S_SUM_HI;
					end else begin
						state_d = S_DHI;
						rd_en   = 1'b1;
						rd_addr = idx_next[IDX_W-1:0];
					end
				end
				S_SUM_HI: state_d = S_SUM_LO;
				S_SUM_LO: state_d = S_NL;
				S_NL:     state_d = pend_eof_q ? S_HEAD : S_IDLE;
				default:  state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_eof_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				pend_eof_q <= cmd.data_rec && cmd.eof;
			end else if (load_eof) begin
				pend_eof_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			count_q <= ld_count;
			addr_q  <= ld_addr;
			type_q  <= ld_type;
			sum_q   <= ld_sum;
			hdr_q   <= 4'd0;
			idx_q   <= '0;
		end else if (adv) begin
			case (state_q)
				S_HEAD: hdr_q <= hdr_q + 4'd1;
				S_DLO: begin
					sum_q <= sum_q + rd_data;
					idx_q <= idx_next;
				end
				default: ;
			endcase
		end
		if (adv) begin
			out_data_q.out_char  <= char_d;
			out_data_q.last_char <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == S_IDLE)
		else $error("record request while the sequencer is busy");

	a_read_leads_digit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> state_q == S_DHI)
		else $error("store read not followed by a high data digit");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DHI || state_q == S_DLO) |-> idx_q < count_q)
		else $error("data index beyond record length");

	a_last_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.last_char) |-> out_data_q.out_char == CH_NL)
		else $error("final character of an item is not a newline");
`endif

endmodule

FILE: design/hex_record_stream_encoder.sv
// ----------------------------------------------------------------------------
// hex_record_stream_encoder: Intel HEX data record encoder, top level
// Gathers data bytes into a record buffer and streams the record text.
// ----------------------------------------------------------------------------
// A data byte that does not complete a record is stored and produces no
// beats. The byte that completes a record of RECORD_BYTES bytes starts the
// record sequencer, which sends one ASCII character per cycle while
// out_ready is high: 9 header characters, two per data byte, two checksum
// characters and a newline, so 44 beats for the default 16-byte record. An
// end-of-input request sends a pending partial record, if any, and then the
// 12-character end-of-file record, and returns the load address and fill
// count to zero. Input is held off (in_ready low) from the cycle after the
// request that starts a record until its final character has entered the
// output register; the last character may still be waiting for out_ready
// when the next byte is taken. No byte is taken while a record is being
// sent, so loading and sending do not overlap. The final character of every
// request carries last_char. Load addresses wrap at 16 bits and no
// extended-address records are made.
// ----------------------------------------------------------------------------
module hex_record_stream_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hrse_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hrse_pkg::out_beat_t out_data
);
	import hrse_pkg::*;

	logic [IDX_W-1:0]  fill_q;
	logic [ADDR_W-1:0] addr_q;
	logic              accept;
	logic              is_eof;
	logic              full;
	logic              busy;
	cmd_t              cmd;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [7:0]        rd_data;

	// New requests are taken only while no record is being sequenced.
	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;
	assign is_eof   = (in_data.req_type == REQ_EOF);
	assign full     = (fill_q == IDX_W'(RECORD_BYTES - 1));

	// A record starts when a byte fills the buffer, or on end of input. On end
	// of input the data record is only sent when bytes are pending.
	always_comb begin
		cmd.start    = accept && (is_eof || full);
		cmd.eof      = is_eof;
		cmd.data_rec = is_eof ? (fill_q != '0) : 1'b1;
		cmd.count    = is_eof ? CNT_W'(fill_q) : CNT_W'(RECORD_BYTES);
		cmd.addr     = addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			addr_q <= '0;
		end else if (accept) begin
			if (is_eof) begin
				fill_q <= '0;
				addr_q <= '0;
			end else if (full) begin
				fill_q <= '0;
				addr_q <= addr_q + ADDR_W'(RECORD_BYTES);
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Record buffer: written by incoming bytes, read by the sequencer.
	hrse_ram #(
		.WIDTH(8),
		.DEPTH(RECORD_BYTES)
	) u_store (
		.clk  (clk),
		.we   (accept && !is_eof),
		.waddr(fill_q),
		.wdata(in_data.data_byte),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	hrse_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
